### rtl/core/s2i_pkg.sv
// ----------------------------------------------------------------------------
// String-to-integer parser package
// Shared types, codes and constants for the streaming signed-integer parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package s2i_pkg;

  localparam int DEF_VALUE_WIDTH = 64;
  localparam int DEF_MAX_CHARS   = 65535;

  localparam int CH_W     = 8;
  localparam int BASE_W   = 6;
  localparam int DIGIT_W  = 6;
  localparam int RVALUE_W = 64;
  localparam int OFFSET_W = 16;

  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_UNARY = 6'd1;

  localparam logic [CH_W-1:0] CH_LX    = 8'h78;  // 'x'
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;  // 'X'
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SPACE  = 3'd1,
    PH_SIGNED = 3'd2,
    PH_ZERO   = 3'd3,
    PH_PREFIX = 3'd4,
    PH_DIGITS = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DIGITS = 2'd1,
    ST_RANGE     = 2'd2,
    ST_BAD_BASE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            start;
  } in_item_t;

  typedef struct packed {
    logic               is_space;
    logic               is_plus;
    logic               is_minus;
    logic               is_zero;
    logic               is_x;
    logic               digit_ok;
    logic [DIGIT_W-1:0] digit;
  } char_class_t;

  typedef struct packed {
    logic [RVALUE_W-1:0] value;
    logic [OFFSET_W-1:0] end_offset;
    status_t             status;
  } result_t;

endpackage

### rtl/core/string_to_signed_integer_parser_top.sv
// ----------------------------------------------------------------------------
// Streaming signed-integer parser
// Parses a character stream in the manner of strtol into a saturated signed
// value, the consumed character count and a status code.
//
//   port group   dir   content
//   s_*          in    tdata[7:0] ch, tuser[0] string_start
//   m_*          out   tdata[63:0] value, tdata[79:64] end_offset,
//                      tuser[1:0] status
//   cfg_*        in    cfg_wr_data[5:0] number_base (write-only)
//
// One character per cycle sustained while the result register is free. A
// character is held in the input register; the parse step is combinational
// and loads the result register at the edge that takes the character, so the
// closing character passes the input register and then the result register.
// The step is one base-by-accumulator multiply-add and a limit compare.
// rst is synchronous; it sets the base to 10 and the parser idle.
// The step stalls only while the result register is full and not taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module string_to_signed_integer_parser_top
  import s2i_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int MAX_CHARS   = DEF_MAX_CHARS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] ch
  input  logic [0:0]  s_tuser,     // [0] string_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,     // [63:0] value, [79:64] end_offset
  output logic [1:0]  m_tuser,     // [1:0] status
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data  // number_base
);

  logic        item_valid;
  in_item_t    item;
  char_class_t cls;
  logic        out_free;
  logic        step_en;
  logic        res_valid;
  result_t     res;

  assign step_en = item_valid && out_free;

  s2i_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .take       (step_en),
    .item_valid (item_valid),
    .item       (item)
  );

  s2i_char_class u_cls (
    .ch  (item.ch),
    .cls (cls)
  );

  s2i_core #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_CHARS   (MAX_CHARS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (step_en),
    .item        (item),
    .cls         (cls),
    .res_valid   (res_valid),
    .res         (res)
  );

  s2i_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step_en && res_valid),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### rtl/core/s2i_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted character until the parse step takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2i_in_stage
  import s2i_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  input  logic [0:0] s_tuser,   // [0] string_start
  input  logic      take,
  output logic      item_valid,
  output in_item_t  item
);

  logic     valid;
  in_item_t item_q;

  assign s_tready   = !valid || take;
  assign item_valid = valid;
  assign item       = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_q.ch    <= s_tdata;
      item_q.start <= s_tuser[0];
    end
  end

endmodule

### rtl/core/s2i_char_class.sv
// ----------------------------------------------------------------------------
// Character classifier
// Decodes one byte into whitespace, sign, prefix and digit-value flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2i_char_class
  import s2i_pkg::*;
(
  input  logic [CH_W-1:0] ch,
  output char_class_t     cls
);

  always_comb begin
    cls          = '0;
    cls.is_space = (ch inside {[8'd9:8'd13], CH_SPACE});
    cls.is_plus  = (ch == CH_PLUS);
    cls.is_minus = (ch == CH_MINUS);
    cls.is_zero  = (ch == CH_ZERO);
    cls.is_x     = (ch == CH_LX) || (ch == CH_UX);
    if (ch inside {[8'h30:8'h39]}) begin
      cls.digit_ok = 1'b1;
      cls.digit    = DIGIT_W'(ch - 8'h30);
    end else if (ch inside {[8'h41:8'h5A]}) begin
      cls.digit_ok = 1'b1;
      cls.digit    = DIGIT_W'(ch - 8'h41 + 8'd10);
    end else if (ch inside {[8'h61:8'h7A]}) begin
      cls.digit_ok = 1'b1;
      cls.digit    = DIGIT_W'(ch - 8'h61 + 8'd10);
    end
  end

endmodule

### rtl/core/s2i_core.sv
// ----------------------------------------------------------------------------
// Parse step
// Parse state registers and the one-character step: whitespace, sign,
// radix prefix, digit multiply-add with range check, and result forming.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2i_core
  import s2i_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int MAX_CHARS   = DEF_MAX_CHARS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [BASE_W-1:0] cfg_wr_data,
  input  logic              step_en,
  input  in_item_t          item,
  input  char_class_t       cls,
  output logic              res_valid,
  output result_t           res
);

  localparam int VW     = VALUE_WIDTH;
  localparam int PW     = $clog2(MAX_CHARS + 1);
  localparam int EW     = (PW > OFFSET_W) ? PW : OFFSET_W;
  localparam int PRODW  = VW + BASE_W + 1;

  localparam logic [PW-1:0] POS_MAX = PW'(MAX_CHARS);
  localparam logic [VW-1:0] POS_LIM = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] NEG_LIM = {1'b1, {(VW-1){1'b0}}};
  localparam logic [EW-1:0] OFS_CAP = EW'({OFFSET_W{1'b1}});

  // state
  logic [BASE_W-1:0] number_base;
  phase_t            phase;
  logic              negative;
  logic [VW-1:0]     acc;
  logic              overflowed;
  logic [BASE_W-1:0] eff_base;
  logic [PW-1:0]     position;
  logic [PW-1:0]     digit_end;

  phase_t            phase_next;
  logic              negative_next;
  logic [VW-1:0]     acc_next;
  logic              overflowed_next;
  logic [BASE_W-1:0] eff_base_next;
  logic [PW-1:0]     position_next;
  logic [PW-1:0]     digit_end_next;

  // working values after a possible restart
  phase_t            cur_phase;
  logic              cur_neg;
  logic [VW-1:0]     cur_acc;
  logic              cur_ovf;
  logic [BASE_W-1:0] cur_base;
  logic [PW-1:0]     cur_pos;
  logic [PW-1:0]     cur_dend;

  logic              bad_base;
  logic [PW-1:0]     npos;
  logic [BASE_W-1:0] step_base;
  logic              dig_take;
  logic [VW-1:0]     limit;
  logic [PRODW-1:0]  prod;
  logic              fits;
  logic [VW-1:0]     acc_take;
  logic              ovf_take;
  logic signed [VW-1:0] final_val;
  logic [EW-1:0]     dend_ext;
  logic [OFFSET_W-1:0] final_ofs;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_DEC;
    end else if (cfg_wr_en) begin
      number_base <= cfg_wr_data;
    end
  end

  always_comb begin
    bad_base = item.start &&
               ((number_base == BASE_UNARY) || (number_base > BASE_MAX));
    if (item.start) begin
      cur_phase = PH_SPACE;
      cur_neg   = 1'b0;
      cur_acc   = '0;
      cur_ovf   = 1'b0;
      cur_base  = number_base;
      cur_pos   = '0;
      cur_dend  = '0;
    end else begin
      cur_phase = phase;
      cur_neg   = negative;
      cur_acc   = acc;
      cur_ovf   = overflowed;
      cur_base  = eff_base;
      cur_pos   = position;
      cur_dend  = digit_end;
    end

    npos = (cur_pos >= POS_MAX) ? POS_MAX : cur_pos + PW'(1);

    // auto base resolves to 10 on a plain digit, to 8 after a leading zero
    case (cur_phase)
      PH_SPACE, PH_SIGNED: step_base = (cur_base == BASE_AUTO) ? BASE_DEC : cur_base;
      PH_ZERO:             step_base = (cur_base == BASE_AUTO) ? BASE_OCT : cur_base;
      default:             step_base = cur_base;
    endcase

    dig_take = cls.digit_ok && (BASE_W'(cls.digit) < step_base);

    limit    = cur_neg ? NEG_LIM : POS_LIM;
    prod     = PRODW'(cur_acc) * PRODW'(step_base) + PRODW'(cls.digit);
    fits     = (prod <= PRODW'(limit));
    ovf_take = cur_ovf || !fits;
    acc_take = ovf_take ? cur_acc : prod[VW-1:0];

    if (cur_ovf) begin
      final_val = cur_neg ? NEG_LIM : POS_LIM;
    end else begin
      final_val = cur_neg ? (VW'(0) - cur_acc) : cur_acc;
    end
    dend_ext  = EW'(cur_dend);
    final_ofs = (dend_ext > OFS_CAP) ? {OFFSET_W{1'b1}} : dend_ext[OFFSET_W-1:0];

    phase_next      = cur_phase;
    negative_next   = cur_neg;
    acc_next        = cur_acc;
    overflowed_next = cur_ovf;
    eff_base_next   = cur_base;
    position_next   = npos;
    digit_end_next  = cur_dend;
    res_valid       = 1'b0;
    res             = '0;
    res.status      = ST_OK;

    if (bad_base) begin
      phase_next    = PH_IDLE;
      position_next = '0;
      res_valid     = 1'b1;
      res.status    = ST_BAD_BASE;
    end else begin
      case (cur_phase)
        PH_SPACE, PH_SIGNED: begin
          if (cur_phase == PH_SPACE && cls.is_space) begin
            phase_next = PH_SPACE;
          end else if (cur_phase == PH_SPACE && (cls.is_plus || cls.is_minus)) begin
            negative_next = cls.is_minus;
            phase_next    = PH_SIGNED;
          end else if (cls.is_zero &&
                       (cur_base == BASE_AUTO || cur_base == BASE_HEX)) begin
            // hold the zero: it may open a 0x prefix
            digit_end_next = npos;
            phase_next     = PH_ZERO;
          end else begin
            eff_base_next = step_base;
            if (dig_take) begin
              acc_next        = acc_take;
              overflowed_next = ovf_take;
              digit_end_next  = npos;
              phase_next      = PH_DIGITS;
            end else begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.status = ST_NO_DIGITS;
            end
          end
        end
        PH_ZERO: begin
          if (cls.is_x) begin
            eff_base_next = BASE_HEX;
            phase_next    = PH_PREFIX;
          end else begin
            eff_base_next = step_base;
            if (dig_take) begin
              acc_next        = acc_take;
              overflowed_next = ovf_take;
              digit_end_next  = npos;
              phase_next      = PH_DIGITS;
            end else begin
              phase_next     = PH_IDLE;
              res_valid      = 1'b1;
              res.value      = RVALUE_W'(final_val);
              res.end_offset = final_ofs;
              res.status     = cur_ovf ? ST_RANGE : ST_OK;
            end
          end
        end
        PH_PREFIX, PH_DIGITS: begin
          if (dig_take) begin
            acc_next        = acc_take;
            overflowed_next = ovf_take;
            digit_end_next  = npos;
            phase_next      = PH_DIGITS;
          end else begin
            phase_next     = PH_IDLE;
            res_valid      = 1'b1;
            res.value      = RVALUE_W'(final_val);
            res.end_offset = final_ofs;
            res.status     = cur_ovf ? ST_RANGE : ST_OK;
          end
        end
        default: begin
          // idle without a start: character ignored
          phase_next    = PH_IDLE;
          position_next = cur_pos;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      negative   <= 1'b0;
      acc        <= '0;
      overflowed <= 1'b0;
      eff_base   <= BASE_DEC;
      position   <= '0;
      digit_end  <= '0;
    end else if (step_en) begin
      phase      <= phase_next;
      negative   <= negative_next;
      acc        <= acc_next;
      overflowed <= overflowed_next;
      eff_base   <= eff_base_next;
      position   <= position_next;
      digit_end  <= digit_end_next;
    end
  end

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    step_en && res_valid |=> phase == PH_IDLE)
    else $error("parser not idle after a result");

  a_acc_in_range: assert property (@(posedge clk) disable iff (rst)
    acc <= NEG_LIM)
    else $error("accumulator beyond the negative limit");

  a_dend_le_pos: assert property (@(posedge clk) disable iff (rst)
    digit_end <= position)
    else $error("digit end past the position");

  a_bad_base_answers: assert property (@(posedge clk) disable iff (rst)
    bad_base |-> res_valid && res.status == ST_BAD_BASE && res.value == '0)
    else $error("invalid base without an immediate status result");

  a_acc_positive_limit: assert property (@(posedge clk) disable iff (rst)
    !negative && phase == PH_DIGITS |-> acc <= POS_LIM)
    else $error("positive accumulator above its limit");

endmodule

### rtl/core/s2i_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2i_out_stage
  import s2i_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  output logic        free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [63:0] value, [79:64] end_offset
  output logic [1:0]  m_tuser    // [1:0] status
);

  logic    valid;
  result_t res_q;

  assign free     = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata  = {res_q.end_offset, res_q.value};
  assign m_tuser  = res_q.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule
